// File: design/oti_pkg.sv
// shared types, constants and helpers for the opacity table interpolation unit
`default_nettype none
package oti_pkg;

   localparam int TEMP_ROWS_DEF = 71;
   localparam int R_COLUMNS_DEF = 20;

   localparam logic [31:0]        LOG2_TEN_Q30 = 32'd3566893132;
   localparam logic [63:0]        LN2_Q64      = 64'hB17217F7D1CF79AB;
   localparam logic signed [35:0] LR_BIAS      = 36'sd1179648;
   localparam logic [4:0]         TAYLOR_TERMS = 5'd24;
   localparam logic signed [18:0] EXP_BIAS     = 19'sd24;

   localparam logic [2:0] SLOT_R0 = 3'd0;
   localparam logic [2:0] SLOT_R1 = 3'd1;
   localparam logic [2:0] SLOT_T0 = 3'd2;
   localparam logic [2:0] SLOT_T1 = 3'd3;
   localparam logic [2:0] SLOT_A  = 3'd4;
   localparam logic [2:0] SLOT_B  = 3'd5;
   localparam logic [2:0] SLOT_C  = 3'd6;
   localparam logic [2:0] SLOT_D  = 3'd7;

   localparam logic [1:0] LERP_KMIN = 2'd0;
   localparam logic [1:0] LERP_KMAX = 2'd1;
   localparam logic [1:0] LERP_T    = 2'd2;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [6:0]         row;
      logic [4:0]         column;
      logic signed [31:0] entry_value;
      logic signed [31:0] log_temp;
      logic signed [31:0] log_density;
   } req_type;

   typedef struct packed {
      logic signed [31:0] log_opacity;
      logic [63:0]        opacity;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [32:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_TRD,
      ST_TCMP,
      ST_JRD,
      ST_JCMP,
      ST_FETCH,
      ST_LMUL,
      ST_LMULW,
      ST_LDIV,
      ST_PY,
      ST_PYW,
      ST_PG1,
      ST_PG2,
      ST_PG3,
      ST_TADD,
      ST_TM0,
      ST_TM1,
      ST_TM2,
      ST_TM3,
      ST_TM4,
      ST_TDS,
      ST_TDIV,
      ST_OUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
      logic signed [31:0] r;
      if (v > 65'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -65'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: design/oti_mul.sv
// shared signed 33x33 multiplier with registered product
`default_nettype none
module oti_mul
   import oti_pkg::*;
(
   input  wire logic               clock,
   input  wire logic signed [32:0] mul_a,
   input  wire logic signed [32:0] mul_b,
   output logic signed [63:0]      prod_ff
);
   logic signed [65:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in[63:0];
   end
endmodule
`default_nettype wire

// File: design/oti_div.sv
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none
module oti_div
   import oti_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire div_req_type div_req,
   output div_rsp_type div_rsp
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] dvs_ff, dvs_in;
   logic [63:0] quo_ff, quo_in;
   logic [33:0] rem_sh;
   logic [33:0] diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      rem_sh  = {rem_ff, quo_ff[63]};
      diff    = rem_sh - {1'b0, dvs_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         if (!diff[33]) begin
            rem_in = diff[32:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh[32:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
endmodule
`default_nettype wire

// File: design/opacity_table_bilinear_interp_unit.sv
// top level: table memory, axis search, bilinear interpolation and power of ten
// A write beat stores one table entry; rows or columns beyond the table are dropped. A query
// searches both axes and fetches eight entries through the table memory's single read port,
// then runs three interpolation steps (each takes the lower entry as it is, with no multiply or
// divide, where the axis interval is flat), then 23 Taylor steps, all on one 33x33 multiplier
// and one radix-2 divider. The block takes no new beat while a query is in work, but a finished
// result waits in the output register without blocking the next beat. The table needs no
// clearing pass; entries must be written before use.
`default_nettype none
module opacity_table_bilinear_interp_unit
   import oti_pkg::*;
#(
   parameter int TEMP_ROWS = TEMP_ROWS_DEF,
   parameter int R_COLUMNS = R_COLUMNS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  wire req_type req_data,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output rsp_type   rsp_data
);
   localparam int DEPTH = TEMP_ROWS * R_COLUMNS;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(TEMP_ROWS + 1);
   localparam int JW    = $clog2(R_COLUMNS + 1);

   state_type state_ff, state_in;

   logic [31:0]   mem_ff [DEPTH];
   logic signed [31:0] rd_ff;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;

   logic signed [31:0] lt_ff, lt_in;
   logic signed [35:0] lr_ff, lr_in;
   logic [IW-1:0] i_ff, i_in;
   logic [JW-1:0] j_ff, j_in;
   logic [3:0]    fcnt_ff, fcnt_in;
   logic signed [31:0] slot_ff [8];
   logic          slot_we;
   logic [1:0]    lsel_ff, lsel_in;
   logic signed [31:0] kmin_ff, kmin_in, kmax_ff, kmax_in, lk_ff, lk_in;
   logic          neg_ff, neg_in;
   logic signed [17:0] n_ff, n_in;
   logic [31:0]   f32_ff, f32_in;
   logic [63:0]   ghi_ff, ghi_in, g_ff, g_in, term_ff, term_in, s_ff, s_in;
   logic [4:0]    k_ff, k_in;
   logic [127:0]  acc_ff, acc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [63:0] prod_ff;
   div_req_type   div_req;
   div_rsp_type   div_rsp;

   logic signed [31:0] lo, hi, off;
   logic signed [32:0] dx;
   logic signed [31:0] lerp_res;
   logic signed [63:0] q;
   logic signed [18:0] e;
   logic [6:0]    shamt;

   function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r,
                                                input logic [JW-1:0] c);
      return AW'(32'(r) * R_COLUMNS + 32'(c));
   endfunction

   oti_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   oti_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= req_data.entry_value;
      end
      if (rd_en) begin
         rd_ff <= mem_ff[rd_addr];
      end
   end

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      case (lsel_ff)
         LERP_KMIN: begin
            lo = slot_ff[SLOT_A];
            hi = slot_ff[SLOT_B];
         end
         LERP_KMAX: begin
            lo = slot_ff[SLOT_C];
            hi = slot_ff[SLOT_D];
         end
         default: begin
            lo = kmin_ff;
            hi = kmax_ff;
         end
      endcase
      if (lsel_ff == LERP_T) begin
         off = sat32(65'(lt_ff) - 65'(slot_ff[SLOT_T0]));
         dx  = 33'(slot_ff[SLOT_T1]) - 33'(slot_ff[SLOT_T0]);
      end else begin
         off = sat32(65'(lr_ff) - 65'(slot_ff[SLOT_R0]));
         dx  = 33'(slot_ff[SLOT_R1]) - 33'(slot_ff[SLOT_R0]);
      end
      q        = neg_ff ? -$signed(div_rsp.quotient) : $signed(div_rsp.quotient);
      lerp_res = sat32(65'(lo) + 65'(q));
      e        = 19'(n_ff) + EXP_BIAS;
      shamt    = 7'd64 - e[6:0];
   end

   always_comb begin
      state_in     = state_ff;
      lt_in        = lt_ff;
      lr_in        = lr_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      fcnt_in      = fcnt_ff;
      slot_we      = 1'b0;
      lsel_in      = lsel_ff;
      kmin_in      = kmin_ff;
      kmax_in      = kmax_ff;
      lk_in        = lk_ff;
      neg_in       = neg_ff;
      n_in         = n_ff;
      f32_in       = f32_ff;
      ghi_in       = ghi_ff;
      g_in         = g_ff;
      term_in      = term_ff;
      s_in         = s_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = AW'(32'(req_data.row) * R_COLUMNS + 32'(req_data.column));
      mul_a        = '0;
      mul_b        = '0;
      div_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.operation == OP_WRITE) begin
                  wr_en = (32'(req_data.row) < TEMP_ROWS) && (32'(req_data.column) < R_COLUMNS);
               end else begin
                  lt_in    = req_data.log_temp;
                  lr_in    = 36'(req_data.log_density) - 36'(req_data.log_temp)
                           - (36'(req_data.log_temp) <<< 1) + LR_BIAS;
                  i_in     = IW'(1);
                  j_in     = JW'(1);
                  state_in = ST_TRD;
               end
            end
         end
         ST_TRD: begin
            if (i_ff == IW'(TEMP_ROWS)) begin
               i_in     = IW'(TEMP_ROWS - 1);
               state_in = ST_JRD;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = cell_addr(i_ff, '0);
               state_in = ST_TCMP;
            end
         end
         ST_TCMP: begin
            if (rd_ff < lt_ff) begin
               i_in     = i_ff + IW'(1);
               state_in = ST_TRD;
            end else begin
               if (i_ff == IW'(1)) begin
                  i_in  = IW'(2);
                  lt_in = rd_ff;
               end
               state_in = ST_JRD;
            end
         end
         ST_JRD: begin
            if (j_ff == JW'(R_COLUMNS)) begin
               j_in     = JW'(R_COLUMNS - 1);
               lr_in    = 36'(rd_ff);
               fcnt_in  = '0;
               state_in = ST_FETCH;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = cell_addr('0, j_ff);
               state_in = ST_JCMP;
            end
         end
         ST_JCMP: begin
            if (36'(rd_ff) < lr_ff) begin
               j_in     = j_ff + JW'(1);
               state_in = ST_JRD;
            end else begin
               if (j_ff == JW'(1)) begin
                  j_in  = JW'(2);
                  lr_in = 36'(rd_ff);
               end
               fcnt_in  = '0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            slot_we = (fcnt_ff != '0);
            if (!fcnt_ff[3]) begin
               rd_en = 1'b1;
               case (fcnt_ff[2:0])
                  SLOT_R0: rd_addr = cell_addr('0, j_ff - JW'(1));
                  SLOT_R1: rd_addr = cell_addr('0, j_ff);
                  SLOT_T0: rd_addr = cell_addr(i_ff - IW'(1), '0);
                  SLOT_T1: rd_addr = cell_addr(i_ff, '0);
                  SLOT_A:  rd_addr = cell_addr(i_ff - IW'(1), j_ff - JW'(1));
                  SLOT_B:  rd_addr = cell_addr(i_ff - IW'(1), j_ff);
                  SLOT_C:  rd_addr = cell_addr(i_ff, j_ff - JW'(1));
                  SLOT_D:  rd_addr = cell_addr(i_ff, j_ff);
                  default: rd_addr = '0;
               endcase
               fcnt_in = fcnt_ff + 4'd1;
            end else begin
               lsel_in  = LERP_KMIN;
               state_in = ST_LMUL;
            end
         end
         ST_LMUL: begin
            if (dx == '0) begin
               case (lsel_ff)
                  LERP_KMIN: kmin_in = lo;
                  LERP_KMAX: kmax_in = lo;
                  default:   lk_in   = lo;
               endcase
               lsel_in  = lsel_ff + 2'd1;
               state_in = (lsel_ff == LERP_T) ? ST_PY : ST_LMUL;
            end else begin
               mul_a    = 33'(sat32(65'(hi) - 65'(lo)));
               mul_b    = 33'(off);
               state_in = ST_LMULW;
            end
         end
         ST_LMULW: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
            div_req.divisor  = dx[32] ? 33'(-dx) : 33'(dx);
            neg_in           = prod_ff[63] ^ dx[32];
            state_in         = ST_LDIV;
         end
         ST_LDIV: begin
            if (div_rsp.done) begin
               case (lsel_ff)
                  LERP_KMIN: kmin_in = lerp_res;
                  LERP_KMAX: kmax_in = lerp_res;
                  default:   lk_in   = lerp_res;
               endcase
               lsel_in  = lsel_ff + 2'd1;
               state_in = (lsel_ff == LERP_T) ? ST_PY : ST_LMUL;
            end
         end
         ST_PY: begin
            mul_a    = 33'(lk_ff);
            mul_b    = $signed({1'b0, LOG2_TEN_Q30});
            state_in = ST_PYW;
         end
         ST_PYW: begin
            n_in     = prod_ff[63:46];
            f32_in   = prod_ff[45:14];
            state_in = ST_PG1;
         end
         ST_PG1: begin
            mul_a    = $signed({1'b0, f32_ff});
            mul_b    = $signed({1'b0, LN2_Q64[63:32]});
            state_in = ST_PG2;
         end
         ST_PG2: begin
            ghi_in   = prod_ff;
            mul_a    = $signed({1'b0, f32_ff});
            mul_b    = $signed({1'b0, LN2_Q64[31:0]});
            state_in = ST_PG3;
         end
         ST_PG3: begin
            g_in     = ghi_ff + {32'd0, prod_ff[63:32]};
            term_in  = ghi_ff + {32'd0, prod_ff[63:32]};
            s_in     = '0;
            k_in     = 5'd1;
            state_in = ST_TADD;
         end
         ST_TADD: begin
            s_in     = s_ff + term_ff;
            state_in = (k_ff == TAYLOR_TERMS) ? ST_OUT : ST_TM0;
         end
         ST_TM0: begin
            mul_a    = $signed({1'b0, term_ff[31:0]});
            mul_b    = $signed({1'b0, g_ff[31:0]});
            state_in = ST_TM1;
         end
         ST_TM1: begin
            acc_in   = {64'd0, prod_ff};
            mul_a    = $signed({1'b0, term_ff[31:0]});
            mul_b    = $signed({1'b0, g_ff[63:32]});
            state_in = ST_TM2;
         end
         ST_TM2: begin
            acc_in   = acc_ff + {32'd0, prod_ff, 32'd0};
            mul_a    = $signed({1'b0, term_ff[63:32]});
            mul_b    = $signed({1'b0, g_ff[31:0]});
            state_in = ST_TM3;
         end
         ST_TM3: begin
            acc_in   = acc_ff + {32'd0, prod_ff, 32'd0};
            mul_a    = $signed({1'b0, term_ff[63:32]});
            mul_b    = $signed({1'b0, g_ff[63:32]});
            state_in = ST_TM4;
         end
         ST_TM4: begin
            acc_in   = acc_ff + {prod_ff, 64'd0};
            state_in = ST_TDS;
         end
         ST_TDS: begin
            div_req.start    = 1'b1;
            div_req.dividend = acc_ff[127:64];
            div_req.divisor  = 33'(k_ff) + 33'd1;
            state_in         = ST_TDIV;
         end
         ST_TDIV: begin
            if (div_rsp.done) begin
               term_in  = div_rsp.quotient;
               k_in     = k_ff + 5'd1;
               state_in = ST_TADD;
            end
         end
         ST_OUT: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in       = 1'b1;
               rsp_in.log_opacity = lk_ff;
               rsp_in.saturated   = 1'b0;
               if (e >= 19'sd64) begin
                  rsp_in.opacity   = '1;
                  rsp_in.saturated = 1'b1;
               end else if (e < 19'sd0) begin
                  rsp_in.opacity = '0;
               end else if (e == 19'sd0) begin
                  rsp_in.opacity = 64'd1;
               end else begin
                  rsp_in.opacity = (64'd1 << e[5:0]) + (s_ff >> shamt);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (slot_we) begin
         slot_ff[fcnt_ff[2:0] - 3'd1] <= rd_ff;
      end
      lt_ff   <= lt_in;
      lr_ff   <= lr_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      fcnt_ff <= fcnt_in;
      lsel_ff <= lsel_in;
      kmin_ff <= kmin_in;
      kmax_ff <= kmax_in;
      lk_ff   <= lk_in;
      neg_ff  <= neg_in;
      n_ff    <= n_in;
      f32_ff  <= f32_in;
      ghi_ff  <= ghi_in;
      g_ff    <= g_in;
      term_ff <= term_in;
      s_ff    <= s_in;
      k_ff    <= k_in;
      acc_ff  <= acc_in;
      rsp_ff  <= rsp_in;
   end
endmodule
`default_nettype wire

// File: design/oti_checker.sv
// port checker for the opacity table interpolation unit, bound to the top level
`default_nettype none
module oti_checker
   import oti_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire req_type req_data,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.operation == OP_QUERY |=> req_stall)
      else $error("query beat did not hold off the input");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.operation == OP_WRITE && !rsp_valid |=> !rsp_valid)
      else $error("write beat produced a result");

   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |-> rsp_data.opacity == '1)
      else $error("saturated result not clamped");
endmodule

bind opacity_table_bilinear_interp_unit oti_checker u_oti_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// File: dv/testbench.sv
// self-checking bench for the opacity table interpolation unit: directed and random beats
`default_nettype none
module testbench;
   import oti_pkg::*;

   localparam int  ROWS  = TEMP_ROWS_DEF;
   localparam int  COLS  = R_COLUMNS_DEF;
   localparam int  RANDOM_BEATS = 850;
   localparam longint CYCLE_LIMIT = 12_000_000;
   localparam logic signed [31:0] Q_ONE = 32'sd65536;

   typedef struct {
      req_type beat;
      bit      known;
      rsp_type want;
   } step_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   logic signed [31:0] opacity_shadow [ROWS*COLS];
   rsp_type  pending_opacity [$];
   step_type directed_steps [$];

   int     mismatches = 0;
   int     results_seen = 0;
   int     writes_sent = 0;
   int     queries_sent = 0;
   int     saturations = 0;
   int     hold_left = 0;
   bit     hold_done = 0;
   longint cycles = 0;

   opacity_table_bilinear_interp_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic bit quiet_window();
      return results_seen >= 60 && results_seen < 110;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint entry_at(int r, int c);
      return longint'(opacity_shadow[r*COLS + c]);
   endfunction

   function automatic longint blend(longint lo, longint hi, longint off, longint dx);
      longint q;
      if (dx == 0) return clamp32(lo);
      q = (clamp32(hi - lo) * clamp32(off)) / dx;
      return clamp32(lo + q);
   endfunction

   function automatic rsp_type predict_opacity(logic signed [31:0] lt_in,
                                               logic signed [31:0] ld_in);
      longint lt, lr, t0, t1, r0, r1, kmin, kmax, lk, y, n, e;
      int i, j;
      logic [63:0] f32, g, term, s;
      logic [127:0] prod;
      rsp_type r;
      lt = longint'(lt_in);
      lr = longint'(ld_in) - 3 * (lt - 6 * 65536);
      i = 1;
      while (i < ROWS && entry_at(i, 0) < lt) i++;
      if (i == 1) begin
         i = 2;
         lt = entry_at(1, 0);
      end else if (i == ROWS) begin
         i--;
      end
      j = 1;
      while (j < COLS && entry_at(0, j) < lr) j++;
      if (j == 1) begin
         j = 2;
         lr = entry_at(0, 1);
      end else if (j == COLS) begin
         j--;
         lr = entry_at(0, COLS - 1);
      end
      r0 = entry_at(0, j - 1);
      r1 = entry_at(0, j);
      t0 = entry_at(i - 1, 0);
      t1 = entry_at(i, 0);
      kmin = blend(entry_at(i - 1, j - 1), entry_at(i - 1, j), lr - r0, r1 - r0);
      kmax = blend(entry_at(i, j - 1), entry_at(i, j), lr - r0, r1 - r0);
      lk = blend(kmin, kmax, lt - t0, t1 - t0);
      y = lk * 64'sd3566893132;
      n = y >>> 46;
      f32 = 64'(y - n * 64'sd70368744177664) >> 14;
      g = f32 * {32'd0, LN2_Q64[63:32]} + ((f32 * {32'd0, LN2_Q64[31:0]}) >> 32);
      s = '0;
      term = g;
      for (int k = 1; k <= 24; k++) begin
         s += term;
         prod = {64'd0, term} * {64'd0, g};
         term = prod[127:64] / 64'(k + 1);
      end
      e = n + 24;
      r.log_opacity = lk[31:0];
      r.saturated = 1'b0;
      if (e >= 64) begin
         r.opacity = '1;
         r.saturated = 1'b1;
      end else if (e < 0) begin
         r.opacity = '0;
      end else if (e == 0) begin
         r.opacity = 64'd1;
      end else begin
         r.opacity = (64'd1 << e) + (s >> (64 - e));
      end
      return r;
   endfunction

   function automatic req_type write_beat(int r, int c, logic signed [31:0] v);
      req_type b;
      b = '0;
      b.operation = OP_WRITE;
      b.row = 7'(r);
      b.column = 5'(c);
      b.entry_value = v;
      b.log_temp = $urandom;
      b.log_density = $urandom;
      return b;
   endfunction

   function automatic req_type query_beat(logic signed [31:0] lt, logic signed [31:0] ld);
      req_type b;
      b = '0;
      b.operation = OP_QUERY;
      b.row = $urandom;
      b.column = $urandom;
      b.entry_value = $urandom;
      b.log_temp = lt;
      b.log_density = ld;
      return b;
   endfunction

   function automatic logic signed [31:0] t_axis(int r);
      return 3 * Q_ONE + (r - 1) * 5698;
   endfunction

   function automatic logic signed [31:0] r_axis(int c);
      return -8 * Q_ONE + (c - 1) * 32768;
   endfunction

   task automatic send(req_type b, bit known, rsp_type want);
      int gap;
      @(negedge clock);
      if (!quiet_window() && $urandom_range(99) < 10) begin
         gap = $urandom_range(4, 1);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (req_stall);
      if (b.operation == OP_WRITE) begin
         writes_sent++;
         if (b.row < ROWS && b.column < COLS)
            opacity_shadow[b.row*COLS + b.column] = b.entry_value;
      end else begin
         queries_sent++;
         pending_opacity.push_back(known ? want : predict_opacity(b.log_temp, b.log_density));
      end
   endtask

   task automatic fill_table(bit random_body);
      rsp_type none;
      logic signed [31:0] v;
      none = '0;
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < COLS; c++) begin
            if (r == 0) v = (c == 0) ? 32'sd0 : r_axis(c);
            else if (c == 0) v = t_axis(r);
            else if (random_body) v = $urandom_range(12 * 65536) - 6 * 65536;
            else v = 32'sd0;
            send(write_beat(r, c, v), 1'b0, none);
         end
      end
   endtask

   function automatic step_type row_of(req_type b, bit known, rsp_type want);
      step_type s;
      s.beat = b;
      s.known = known;
      s.want = want;
      return s;
   endfunction

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= 20) begin
         rsp_stall <= 1'b1;
         hold_left <= 6000;
         hold_done <= 1'b1;
      end else if (quiet_window()) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 10);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, pending_opacity.size());
         $display("TB_ERROR");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_data.saturated) saturations++;
         if (pending_opacity.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %p", rsp_data);
         end else begin
            want = pending_opacity.pop_front();
            if (rsp_data.log_opacity !== want.log_opacity || rsp_data.opacity !== want.opacity
                || rsp_data.saturated !== want.saturated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected log %h val %h sat %b, got log %h val %h sat %b",
                           results_seen, want.log_opacity, want.opacity, want.saturated,
                           rsp_data.log_opacity, rsp_data.opacity, rsp_data.saturated);
            end
         end
      end
   end

   initial begin
      rsp_type zero_rsp, unity_rsp, none;
      req_type b;
      logic signed [31:0] lt, lr, ld;
      int pick, r, c;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      none = '0;
      unity_rsp = '0;
      unity_rsp.opacity = 64'h1000000;
      zero_rsp = unity_rsp;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // flat zero body: every query reads log 0, opacity one
      fill_table(1'b0);
      directed_steps.push_back(row_of(query_beat(6 * Q_ONE, -3 * Q_ONE), 1'b1, unity_rsp));
      directed_steps.push_back(row_of(query_beat(32'sh7FFFFFFF, 32'sh80000000), 1'b1, zero_rsp));
      directed_steps.push_back(row_of(query_beat(32'sh80000000, 32'sh7FFFFFFF), 1'b1, zero_rsp));
      directed_steps.push_back(row_of(query_beat(32'sd0, 32'sd0), 1'b1, zero_rsp));
      directed_steps.push_back(row_of(write_beat(127, 5, 32'sh7FFFFFFF), 1'b0, none));
      directed_steps.push_back(row_of(write_beat(3, 31, 32'sh80000000), 1'b0, none));
      directed_steps.push_back(row_of(write_beat(ROWS, COLS, 32'sh7FFFFFFF), 1'b0, none));
      directed_steps.push_back(row_of(query_beat(6 * Q_ONE, -3 * Q_ONE), 1'b1, unity_rsp));
      foreach (directed_steps[k]) send(directed_steps[k].beat, directed_steps[k].known,
                                       directed_steps[k].want);
      directed_steps.delete();

      // random body, then writes to the corners of the table, extreme entries and axis cells, and queries
      fill_table(1'b1);
      for (int k = 0; k < 2; k++) begin
         for (int m = 0; m < 2; m++) begin
            directed_steps.push_back(row_of(write_beat(ROWS-2+k, COLS-2+m, 20 * Q_ONE),
                                            1'b0, none));
            directed_steps.push_back(row_of(write_beat(1+k, 1+m, -20 * Q_ONE), 1'b0, none));
         end
      end
      directed_steps.push_back(row_of(write_beat(35, 10, 32'sh7FFFFFFF), 1'b0, none));
      directed_steps.push_back(row_of(write_beat(35, 11, 32'sh80000000), 1'b0, none));
      directed_steps.push_back(row_of(query_beat(10 * Q_ONE, 8 * Q_ONE), 1'b0, none));
      directed_steps.push_back(row_of(query_beat(2 * Q_ONE, -20 * Q_ONE), 1'b0, none));
      directed_steps.push_back(row_of(query_beat(t_axis(35) + 100, -3 * Q_ONE), 1'b0, none));
      directed_steps.push_back(row_of(query_beat(t_axis(20), r_axis(7)), 1'b0, none));
      directed_steps.push_back(row_of(query_beat(t_axis(ROWS-1), 32'sh7FFFFFFF), 1'b0, none));
      directed_steps.push_back(row_of(write_beat(2, 0, t_axis(1)), 1'b0, none));
      directed_steps.push_back(row_of(write_beat(0, 2, r_axis(1)), 1'b0, none));
      directed_steps.push_back(row_of(query_beat(Q_ONE, -30 * Q_ONE), 1'b0, none));
      directed_steps.push_back(row_of(write_beat(2, 0, t_axis(2)), 1'b0, none));
      directed_steps.push_back(row_of(write_beat(0, 2, r_axis(2)), 1'b0, none));
      foreach (directed_steps[k]) send(directed_steps[k].beat, directed_steps[k].known,
                                       directed_steps[k].want);

      for (int k = 0; k < RANDOM_BEATS; k++) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            if ($urandom_range(9) == 0) begin
               lt = $urandom;
               ld = $urandom;
            end else begin
               lt = $urandom_range(10 * Q_ONE) + (Q_ONE * 5) / 2;
               lr = $urandom_range(11 * Q_ONE) - 9 * Q_ONE;
               ld = lr + 3 * (lt - 6 * Q_ONE);
            end
            b = query_beat(lt, ld);
         end else if (pick < 35) begin
            b = write_beat($urandom_range(127), $urandom_range(31), $urandom);
         end else if (pick < 40) begin
            if ($urandom_range(1)) begin
               r = $urandom_range(ROWS - 1, 1);
               b = write_beat(r, 0, t_axis(r) + $urandom_range(8000) - 4000);
            end else begin
               c = $urandom_range(COLS - 1, 1);
               b = write_beat(0, c, r_axis(c) + $urandom_range(40000) - 20000);
            end
         end else begin
            r = $urandom_range(ROWS - 1, 1);
            c = $urandom_range(COLS - 1, 1);
            if ($urandom_range(9) == 0) b = write_beat(r, c, $urandom);
            else b = write_beat(r, c, $urandom_range(16 * Q_ONE) - 8 * Q_ONE);
         end
         send(b, 1'b0, none);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (pending_opacity.size() != 0) @(posedge clock);
      repeat (2200) @(posedge clock);
      $display("sent %0d table writes and %0d queries; %0d results checked, %0d saturated",
               writes_sent, queries_sent, results_seen, saturations);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0 && pending_opacity.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: filelist.f
design/oti_pkg.sv
design/oti_mul.sv
design/oti_div.sv
design/opacity_table_bilinear_interp_unit.sv
design/oti_checker.sv
dv/testbench.sv
